// File: sv/mtw_pkg.sv
// ----------------------------------------------------------------------------
// mtw_pkg
// Shared types and constants for the mask transition texel writer.
// ----------------------------------------------------------------------------
package mtw_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_TILE_SIDE    = 3'd2,
    CFG_PROGRESS     = 3'd3,
    CFG_FADE_IN      = 3'd4
  } cfg_idx_t;

  localparam int unsigned DIM_W   = 11;
  localparam int unsigned PROG_W  = 16;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned ALPHA_W = 8;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd256;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd256;
  localparam logic [DIM_W-1:0]  RST_TILE_SIDE    = 11'd1024;
  localparam logic [PROG_W-1:0] RST_PROGRESS     = 16'd0;
  localparam logic              RST_FADE_IN      = 1'b1;

  // Soft threshold arithmetic: ramp distance d = 131072*v - 765*q + 255*65536
  localparam int unsigned       RAMP_W     = 28;
  localparam logic [9:0]        RAMP_SLOPE = 10'd765;
  localparam logic [RAMP_W-1:0] RAMP_TOP   = 28'd16711680;
  localparam logic [16:0]       Q_ONE      = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

  // Control of the two-stage pipeline
  typedef struct packed {
    logic s1_load;   // stage 1 takes a new beat
    logic advance;   // stage 1 moves into the result register
  } pipe_ctl_t;

endpackage

// File: sv/mtw_raster_cnt.sv
// ----------------------------------------------------------------------------
// mtw_raster_cnt
// Column and row counters that follow the raster position of the mask.
// ----------------------------------------------------------------------------
module mtw_raster_cnt
  import mtw_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 1024,
  parameter int unsigned CNT_W    = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  output logic [CNT_W-1:0] column,
  output logic [CNT_W-1:0] row,
  output logic             frame_last
);

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_SIDE);

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             row_end;

  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width > MAX_DIM) begin
      w_eff = MAX_DIM;
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height > MAX_DIM) begin
      h_eff = MAX_DIM;
    end else begin
      h_eff = image_height;
    end
  end

  // A counter past the bound after a size change still ends the row/frame
  assign row_end    = DIM_W'(col_r) >= (w_eff - DIM_W'(1));
  assign frame_last = row_end && (DIM_W'(row_r) >= (h_eff - DIM_W'(1)));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign column = col_r;
  assign row    = row_r;

endmodule

// File: sv/mtw_alpha.sv
// ----------------------------------------------------------------------------
// mtw_alpha
// Soft threshold of one mask byte against the transition progress.
// ----------------------------------------------------------------------------
module mtw_alpha
  import mtw_pkg::*;
(
  input  logic [MASK_W-1:0]  mask_value,
  input  logic [PROG_W-1:0]  progress,
  input  logic               fade_in,
  output logic [ALPHA_W-1:0] alpha
);

  logic [MASK_W-1:0] v;
  logic [16:0]       q;
  logic [RAMP_W-1:0] v_term;
  logic [RAMP_W-1:0] q_term;
  logic [RAMP_W-1:0] d;

  // Fade in inverts the mask, fade out inverts the progress
  assign v      = fade_in ? ~mask_value : mask_value;
  assign q      = fade_in ? {1'b0, progress} : Q_ONE - {1'b0, progress};
  assign v_term = {3'b000, v, 17'd0};
  assign q_term = RAMP_W'(q) * RAMP_W'(RAMP_SLOPE);
  assign d      = v_term - q_term + RAMP_TOP;

  always_comb begin
    if (d[RAMP_W-1]) begin
      alpha = '0;
    end else if (d >= RAMP_TOP) begin
      alpha = ALPHA_MAX;
    end else begin
      alpha = d[23:16];
    end
  end

endmodule

// File: sv/mtw_addr.sv
// ----------------------------------------------------------------------------
// mtw_addr
// Mirrored, 8x8 tiled Morton texel address for one raster position.
// ----------------------------------------------------------------------------
module mtw_addr
  import mtw_pkg::*;
#(
  parameter int unsigned CNT_W = 10
) (
  input  logic [DIM_W-1:0]  tile_side,
  input  logic [CNT_W-1:0]  column,
  input  logic [CNT_W-1:0]  row,
  output logic [ADDR_W-1:0] texel_address
);

  localparam int unsigned TILE_W = ADDR_W - 6;

  logic [ADDR_W-1:0]   ix;
  logic [TILE_W+7:0]   prod;
  logic [TILE_W-1:0]   tile;
  logic [5:0]          low;

  // Mirror the column across the texture
  assign ix   = ADDR_W'(tile_side) - ADDR_W'(1) - ADDR_W'(column);
  assign prod = ix[TILE_W+2:3] * tile_side[DIM_W-1:3];
  assign tile = prod[TILE_W-1:0] + TILE_W'(row >> 3);
  assign low  = {ix[2], row[2], ix[1], row[1], ix[0], row[0]};

  assign texel_address = {tile, low};

endmodule

// File: sv/mask_transition_tiled_texel_writer_top.sv
// ----------------------------------------------------------------------------
// mask_transition_tiled_texel_writer_top
// Streams mask bytes in raster order and emits one thresholded texel with
// its tiled Morton address per byte.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Beat
//  --------+-----------------------------------------+--------------------------
//  in      | in_valid, in_stall, in_mask_value       | one mask byte
//  out     | out_valid, out_stall, out_texel_*,      | one texel, frame_end on
//          | out_frame_end                           | last pixel of the frame
//  cfg     | cfg_wr_en, cfg_index, cfg_wr_data       | one register write
//
//  Rate: one beat per cycle sustained while out_stall is low. A taken beat
//  passes through the input register, then the result register, before
//  out_valid rises.
//  Reset: counters at zero, registers at their defaults, pipeline empty.
//  Stalls: the result register holds while out_stall is high; stage 1 keeps
//  accepting until it is also full, then in_stall rises.
// ----------------------------------------------------------------------------
module mask_transition_tiled_texel_writer_top
  import mtw_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MASK_W-1:0]  in_mask_value,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  out_texel_address,
  output logic [ALPHA_W-1:0] out_texel_alpha,
  output logic               out_frame_end,
  // configuration writes
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [PROG_W-1:0]  cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(MAX_SIDE);

  // Configuration registers
  logic [DIM_W-1:0]  image_width_r;
  logic [DIM_W-1:0]  image_height_r;
  logic [DIM_W-1:0]  tile_side_r;
  logic [PROG_W-1:0] progress_r;
  logic              fade_in_r;

  // Stage 1: captured byte and raster position
  logic              s1_valid_r, s1_valid_nxt;
  logic [MASK_W-1:0] s1_mask_r;
  logic [CNT_W-1:0]  s1_col_r;
  logic [CNT_W-1:0]  s1_row_r;
  logic              s1_last_r;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [ALPHA_W-1:0] out_alpha_r;
  logic               out_last_r;

  logic [CNT_W-1:0]   cur_col;
  logic [CNT_W-1:0]   cur_row;
  logic               cur_last;
  logic [ADDR_W-1:0]  addr_c;
  logic [ALPHA_W-1:0] alpha_c;
  pipe_ctl_t          ctl;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      tile_side_r    <= RST_TILE_SIDE;
      progress_r     <= RST_PROGRESS;
      fade_in_r      <= RST_FADE_IN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wr_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wr_data[DIM_W-1:0];
        CFG_TILE_SIDE:    tile_side_r    <= cfg_wr_data[DIM_W-1:0];
        CFG_PROGRESS:     progress_r     <= cfg_wr_data;
        CFG_FADE_IN:      fade_in_r      <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: advance whenever the result register is free or drains
  assign ctl.advance = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !ctl.advance;
  assign ctl.s1_load = in_valid && !in_stall;

  // Step the raster counters on every accepted beat
  mtw_raster_cnt #(
    .MAX_SIDE (MAX_SIDE),
    .CNT_W    (CNT_W)
  ) u_cnt (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (ctl.s1_load),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .column       (cur_col),
    .row          (cur_row),
    .frame_last   (cur_last)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (ctl.s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (ctl.advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = ctl.advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the byte with the position it belongs to
  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1_mask_r <= in_mask_value;
      s1_col_r  <= cur_col;
      s1_row_r  <= cur_row;
      s1_last_r <= cur_last;
    end
  end

  mtw_alpha u_alpha (
    .mask_value (s1_mask_r),
    .progress   (progress_r),
    .fade_in    (fade_in_r),
    .alpha      (alpha_c)
  );

  mtw_addr #(
    .CNT_W (CNT_W)
  ) u_addr (
    .tile_side     (tile_side_r),
    .column        (s1_col_r),
    .row           (s1_row_r),
    .texel_address (addr_c)
  );

  // Load the result register; hold it while the consumer stalls
  always_ff @(posedge clk) begin
    if (ctl.advance && s1_valid_r) begin
      out_addr_r  <= addr_c;
      out_alpha_r <= alpha_c;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_texel_address = out_addr_r;
  assign out_texel_alpha   = out_alpha_r;
  assign out_frame_end     = out_last_r;

`ifndef SYNTHESIS
  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted beat did not reach stage 1");

  a_s1_moves_out : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && ctl.advance) |=> out_valid_r)
    else $error("stage 1 beat lost on the way to the result register");

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_addr_r)
                                    && $stable(out_alpha_r)))
    else $error("stalled result changed");
`endif

endmodule
